// ===== src/rpo_pkg.sv =====
// ----------------------------------------------------------------------------
// rpo_pkg: shared types and constants of the point rotator
// Holds the datapath widths, the per-stage vector type and the arctangent
// table that drives the micro-rotation cells.
// ----------------------------------------------------------------------------
package rpo_pkg;

    // Field and datapath widths.
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int GUARD_BITS   = 12;
    localparam int XY_W         = 32;
    localparam int Z_W          = 33;
    localparam int GAIN_W       = 33;
    localparam int PROD_W       = XY_W + GAIN_W;
    localparam int ROUND_SHIFT  = 44;

    // Iteration count and table size.
    localparam int ITERATIONS_DEFAULT = 16;
    localparam int ATAN_ENTRIES       = 24;

    // Quarter turn in input angle units, and the 1/K gain in Q0.32.
    localparam logic signed [COORD_W-1:0] QUARTER_TURN = 16'sd16384;
    localparam logic [31:0]               INV_GAIN_Q32 = 32'h9B74EDA8;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [XY_W-1:0]    t_xy;
    typedef logic signed [Z_W-1:0]     t_z;

    // One beat of the rotation pipeline: vector, residual angle, centre.
    typedef struct packed {
        t_xy    x;
        t_xy    y;
        t_z     z;
        t_coord cx;
        t_coord cy;
    } t_vec;

    // atan(2^-i) in units of pi/2^31.
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== src/rotate_point_about_origin_core.sv =====
// Each stage is a register: prerotation, one cell per micro-rotation, gain multiply, output.
// Throughput: one point per cycle while i_ready holds.
// A stage takes a new beat whenever it is empty or its successor moves, so bubbles close up.
// Reset: synchronous, active low; clears all valid flags, payload registers are not reset.
// ----------------------------------------------------------------------------
// rotate_point_about_origin_core: pipelined CORDIC point rotator
// Prerotation stage, a chain of micro-rotation cells, then gain correction,
// rounding, centre add-back and saturation.
// ----------------------------------------------------------------------------
module rotate_point_about_origin_core
    import rpo_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEFAULT
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_coord i_point_x,
    input  t_coord i_point_y,
    input  t_coord i_centre_x,
    input  t_coord i_centre_y,
    input  t_coord i_turn_angle,
    output logic   o_valid,
    input  logic   i_ready,
    output t_coord o_rotated_x,
    output t_coord o_rotated_y,
    output logic   o_clipped
);

    // Iterations beyond the arctangent table are not performed.
    localparam int STAGES = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;

    t_vec            w_vec   [0:STAGES];
    logic [STAGES:0] w_valid;
    logic [STAGES:0] w_ready;
    logic            w_post_ready;

    // Difference vector and quarter-turn prerotation.
    rpo_pre u_pre (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_centre_x   (i_centre_x),
        .i_centre_y   (i_centre_y),
        .i_turn_angle (i_turn_angle),
        .o_valid      (w_valid[0]),
        .i_ready      (w_ready[0]),
        .o_vec        (w_vec[0])
    );

    // Chain of micro-rotation cells.
    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        rpo_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_vec   (w_vec[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_vec   (w_vec[g+1])
        );
    end

    assign w_ready[STAGES] = w_post_ready;

    // Gain correction, rounding, centre add-back and saturation.
    rpo_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[STAGES]),
        .o_ready     (w_post_ready),
        .i_vec       (w_vec[STAGES]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rotated_x (o_rotated_x),
        .o_rotated_y (o_rotated_y),
        .o_clipped   (o_clipped)
    );

    // The output is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Input back-pressure only when every stage up to the output holds a beat.
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&w_valid) && o_valid && !i_ready)
        else $error("input stalled while the pipeline has a bubble");

    // A clipped result sits at a saturation limit in at least one coordinate.
    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_rotated_x == 16'sh7FFF) || (o_rotated_x == -16'sh8000) ||
            (o_rotated_y == 16'sh7FFF) || (o_rotated_y == -16'sh8000))
        else $error("clip flag without a saturated coordinate");

endmodule

// ===== src/rpo_pre.sv =====
// ----------------------------------------------------------------------------
// rpo_pre: difference vector and quarter-turn prerotation
// Forms point minus centre with guard bits, takes out a quarter turn so the
// residual angle lies in the convergence range, and registers the result.
// ----------------------------------------------------------------------------
module rpo_pre
    import rpo_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_coord i_point_x,
    input  t_coord i_point_y,
    input  t_coord i_centre_x,
    input  t_coord i_centre_y,
    input  t_coord i_turn_angle,
    output logic   o_valid,
    input  logic   i_ready,
    output t_vec   o_vec
);

    logic                     r_valid;
    t_vec                     r_vec;
    t_vec                     n_vec;
    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    t_xy                      w_x;
    t_xy                      w_y;
    t_coord                   w_ang;
    logic                     w_adv;

    // The stage moves whenever its register is empty or downstream takes it.
    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_vec   = r_vec;

    // Difference at 17 bits, then widened with the guard bits.
    assign w_dx = {i_point_x[COORD_W-1], i_point_x} - {i_centre_x[COORD_W-1], i_centre_x};
    assign w_dy = {i_point_y[COORD_W-1], i_point_y} - {i_centre_y[COORD_W-1], i_centre_y};
    assign w_x  = {{(XY_W-DIFF_W-GUARD_BITS){w_dx[DIFF_W-1]}}, w_dx, {GUARD_BITS{1'b0}}};
    assign w_y  = {{(XY_W-DIFF_W-GUARD_BITS){w_dy[DIFF_W-1]}}, w_dy, {GUARD_BITS{1'b0}}};

    // Quarter-turn prerotation. Exactly minus a quarter turn is left as is.
    always_comb begin
        n_vec.cx = i_centre_x;
        n_vec.cy = i_centre_y;
        if (i_turn_angle >= QUARTER_TURN) begin
            n_vec.x = -w_y;
            n_vec.y = w_x;
            w_ang   = i_turn_angle - QUARTER_TURN;
        end else if (i_turn_angle < -QUARTER_TURN) begin
            n_vec.x = w_y;
            n_vec.y = -w_x;
            w_ang   = i_turn_angle + QUARTER_TURN;
        end else begin
            n_vec.x = w_x;
            n_vec.y = w_y;
            w_ang   = i_turn_angle;
        end
        n_vec.z = {w_ang[COORD_W-1], w_ang, 16'h0000};
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_vec <= n_vec;
        end
    end

endmodule

// ===== src/rpo_cell.sv =====
// ----------------------------------------------------------------------------
// rpo_cell: one CORDIC micro-rotation
// Rotates the vector by plus or minus atan(2^-STAGE) depending on the sign of
// the residual angle and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module rpo_cell
    import rpo_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_vec i_vec,
    output logic o_valid,
    input  logic i_ready,
    output t_vec o_vec
);

    localparam t_z ATAN = t_z'({1'b0, atan_entry(STAGE)});

    logic r_valid;
    t_vec r_vec;
    t_vec n_vec;
    t_xy  w_xs;
    t_xy  w_ys;
    logic w_adv;

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_vec   = r_vec;

    // Arithmetic shifts round toward minus infinity, as required.
    assign w_xs = i_vec.x >>> STAGE;
    assign w_ys = i_vec.y >>> STAGE;

    // A residual angle of zero or more turns counterclockwise.
    always_comb begin
        n_vec.cx = i_vec.cx;
        n_vec.cy = i_vec.cy;
        if (!i_vec.z[Z_W-1]) begin
            n_vec.x = i_vec.x - w_ys;
            n_vec.y = i_vec.y + w_xs;
            n_vec.z = i_vec.z - ATAN;
        end else begin
            n_vec.x = i_vec.x + w_ys;
            n_vec.y = i_vec.y - w_xs;
            n_vec.z = i_vec.z + ATAN;
        end
    end

    // Cell register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_vec <= n_vec;
        end
    end

endmodule

// ===== src/rpo_post.sv =====
// ----------------------------------------------------------------------------
// rpo_post: gain correction, rounding and saturation
// Multiplies by 1/K in one stage, then rounds back to Q16.0, adds the centre
// and saturates to 16 bits in the output register.
// ----------------------------------------------------------------------------
module rpo_post
    import rpo_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_vec   i_vec,
    output logic   o_valid,
    input  logic   i_ready,
    output t_coord o_rotated_x,
    output t_coord o_rotated_y,
    output logic   o_clipped
);

    localparam int RND_W = PROD_W - ROUND_SHIFT;
    localparam int SUM_W = RND_W + 1;
    localparam logic signed [GAIN_W-1:0] GAIN = {1'b0, INV_GAIN_Q32};
    localparam logic signed [PROD_W-1:0] ROUND_BIAS =
        {{(PROD_W-ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    logic                     r_mul_valid;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    t_coord                   r_cx;
    t_coord                   r_cy;
    logic                     r_out_valid;
    t_coord                   r_rot_x;
    t_coord                   r_rot_y;
    logic                     r_clip;
    t_coord                   n_rot_x;
    t_coord                   n_rot_y;
    logic                     n_clip;
    logic                     w_adv_mul;
    logic                     w_adv_out;
    logic signed [PROD_W-1:0] w_bias_x;
    logic signed [PROD_W-1:0] w_bias_y;
    logic signed [SUM_W-1:0]  w_sum_x;
    logic signed [SUM_W-1:0]  w_sum_y;

    assign w_adv_out = !r_out_valid || i_ready;
    assign w_adv_mul = !r_mul_valid || w_adv_out;
    assign o_ready   = w_adv_mul;

    assign o_valid     = r_out_valid;
    assign o_rotated_x = r_rot_x;
    assign o_rotated_y = r_rot_y;
    assign o_clipped   = r_clip;

    // Round half up, drop the fraction, add the centre back.
    assign w_bias_x = r_prod_x + ROUND_BIAS;
    assign w_bias_y = r_prod_y + ROUND_BIAS;
    assign w_sum_x  = {w_bias_x[PROD_W-1], w_bias_x[PROD_W-1:ROUND_SHIFT]}
                    + {{(SUM_W-COORD_W){r_cx[COORD_W-1]}}, r_cx};
    assign w_sum_y  = {w_bias_y[PROD_W-1], w_bias_y[PROD_W-1:ROUND_SHIFT]}
                    + {{(SUM_W-COORD_W){r_cy[COORD_W-1]}}, r_cy};

    // Saturation of each coordinate; either clip raises the flag.
    always_comb begin
        n_clip = 1'b0;
        if (w_sum_x > SAT_HI) begin
            n_rot_x = t_coord'(SAT_HI);
            n_clip  = 1'b1;
        end else if (w_sum_x < SAT_LO) begin
            n_rot_x = t_coord'(SAT_LO);
            n_clip  = 1'b1;
        end else begin
            n_rot_x = w_sum_x[COORD_W-1:0];
        end
        if (w_sum_y > SAT_HI) begin
            n_rot_y = t_coord'(SAT_HI);
            n_clip  = 1'b1;
        end else if (w_sum_y < SAT_LO) begin
            n_rot_y = t_coord'(SAT_LO);
            n_clip  = 1'b1;
        end else begin
            n_rot_y = w_sum_y[COORD_W-1:0];
        end
    end

    // Valid flags of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv_mul) begin
                r_mul_valid <= i_valid;
            end
            if (w_adv_out) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    // Gain multiply stage.
    always_ff @(posedge i_clk) begin
        if (w_adv_mul && i_valid) begin
            r_prod_x <= i_vec.x * GAIN;
            r_prod_y <= i_vec.y * GAIN;
            r_cx     <= i_vec.cx;
            r_cy     <= i_vec.cy;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_adv_out && r_mul_valid) begin
            r_rot_x <= n_rot_x;
            r_rot_y <= n_rot_y;
            r_clip  <= n_clip;
        end
    end

endmodule
